[rtl/rcee_pkg.sv]
`timescale 1ns / 1ps

package rcee_pkg;

  localparam int GRAY_W    = 8;
  localparam int PORT_CW   = 12;
  localparam int TERM_W    = 18;
  localparam int CON_W     = 48;
  localparam int ENT_W     = 34;
  localparam int ENT_OUT_W = 35;
  localparam int EN_W      = 33;
  localparam int EN_OUT_W  = 24;
  localparam int ROOT_W    = 25;
  localparam logic [31:0] LOG10_OF_2_Q30 = 32'd323228497;

  typedef logic [255:0][TERM_W-1:0] ent_tab_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_LOAD,
    ST_ROOT
  } state_t;

  typedef struct packed {
    logic accept;
    logic sqrt_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_done;
    logic sqrt_busy;
    logic out_busy;
  } sts_t;

  // round(g*256*log10(g)): log2 by repeated squaring in Q30, scale, round half up
  function automatic ent_tab_t build_ent_tab();
    ent_tab_t    tab;
    logic [63:0] g;
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] bitv;
    logic [63:0] t;
    tab = '0;
    for (int gi = 2; gi < 256; gi++) begin
      g = 64'(gi);
      n = 64'd0;
      for (int k = 1; k < 8; k++) begin
        if ((g >> k) != 64'd0) n = 64'(k);
      end
      m    = (g << 30) >> n;
      lg   = n << 30;
      bitv = 64'd1 << 29;
      for (int i = 0; i < 30; i++) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m  = m >> 1;
          lg = lg | bitv;
        end
        bitv = bitv >> 1;
      end
      t = (lg * 64'(LOG10_OF_2_Q30)) >> 30;
      t = t * (g << 8);
      t = (t + (64'd1 << 29)) >> 30;
      tab[gi] = t[TERM_W-1:0];
    end
    return tab;
  endfunction

endpackage

[rtl/rcee_sqrt.sv]
`timescale 1ns / 1ps

module rcee_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rcee_pkg::EN_W-1:0]      operand,
  output logic                           busy,
  output logic [rcee_pkg::ROOT_W-1:0]    root
);

  localparam int RW = rcee_pkg::ROOT_W;
  localparam int VW = 2 * RW;
  localparam int MW = RW + 2;

  logic [VW-1:0]         v_r;
  logic [MW-1:0]         rem_r;
  logic [RW-1:0]         root_r;
  logic [4:0]            cnt_r;
  logic                  busy_r;
  logic [MW-1:0]         rem_sh;
  logic [MW-1:0]         trial;

  // one result bit per cycle, two radicand bits brought down
  assign rem_sh = {rem_r[MW-3:0], v_r[VW-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 5'd0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= {{(VW - rcee_pkg::EN_W - 16){1'b0}}, operand, 16'd0};
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= 5'(RW - 1);
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
      v_r   <= v_r << 2;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[rtl/rcee_dp.sv]
`timescale 1ns / 1ps

module rcee_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rcee_pkg::cmd_t                   cmd,
  output rcee_pkg::sts_t                   sts,
  input  logic [rcee_pkg::PORT_CW-1:0]     column,
  input  logic [rcee_pkg::PORT_CW-1:0]     row,
  input  logic [rcee_pkg::GRAY_W-1:0]      gray,
  input  logic                             last_pixel,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [rcee_pkg::CON_W-1:0]       contrast,
  output logic [rcee_pkg::ENT_OUT_W-1:0]   entropy,
  output logic [rcee_pkg::EN_OUT_W-1:0]    energy
);

  localparam int CW = (COORD_BITS < rcee_pkg::PORT_CW) ? COORD_BITS : rcee_pkg::PORT_CW;
  localparam int GW = rcee_pkg::GRAY_W;
  localparam int PW = 2 * CW + GW;
  localparam rcee_pkg::ent_tab_t ENT_TAB = rcee_pkg::build_ent_tab();

  // stage 1
  logic [CW-1:0]                  diff1_r;
  logic [GW-1:0]                  g1_r;
  logic                           v1_r;
  logic                           l1_r;
  // stage 2
  logic [2*CW-1:0]                dsq2_r;
  logic [GW-1:0]                  g2_r;
  logic [rcee_pkg::TERM_W-1:0]    term2_r;
  logic [2*GW-1:0]                gsq2_r;
  logic                           v2_r;
  logic                           l2_r;
  // stage 3
  logic [PW-1:0]                  cprod3_r;
  logic [rcee_pkg::TERM_W-1:0]    term3_r;
  logic [2*GW-1:0]                gsq3_r;
  logic                           v3_r;
  logic                           l3_r;
  // sums and region totals
  logic [rcee_pkg::CON_W-1:0]     con_r;
  logic [rcee_pkg::ENT_W-1:0]     ent_r;
  logic [rcee_pkg::EN_W-1:0]      en_r;
  logic [rcee_pkg::CON_W-1:0]     con_fin_r;
  logic [rcee_pkg::ENT_W-1:0]     ent_fin_r;
  logic [rcee_pkg::EN_W-1:0]      en_fin_r;
  logic [rcee_pkg::CON_W:0]       con_sum;
  logic [rcee_pkg::ENT_W:0]       ent_sum;
  logic [rcee_pkg::EN_W:0]        en_sum;
  logic [rcee_pkg::CON_W-1:0]     con_nxt;
  logic [rcee_pkg::ENT_W-1:0]     ent_nxt;
  logic [rcee_pkg::EN_W-1:0]      en_nxt;
  logic [CW-1:0]                  col_m;
  logic [CW-1:0]                  row_m;
  logic                           out_valid_r;
  logic                           sqrt_busy;
  logic [rcee_pkg::ROOT_W-1:0]    root;

  assign col_m = column[CW-1:0];
  assign row_m = row[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    diff1_r  <= (row_m >= col_m) ? (row_m - col_m) : (col_m - row_m);
    g1_r     <= gray;
    l1_r     <= last_pixel;
    dsq2_r   <= diff1_r * diff1_r;
    g2_r     <= g1_r;
    term2_r  <= ENT_TAB[g1_r];
    gsq2_r   <= g1_r * g1_r;
    l2_r     <= l1_r;
    cprod3_r <= dsq2_r * g2_r;
    term3_r  <= term2_r;
    gsq3_r   <= gsq2_r;
    l3_r     <= l2_r;
  end

  // saturating accumulate: the carry out of each sum marks overflow
  always_comb begin
    con_sum = {1'b0, con_r} + (rcee_pkg::CON_W + 1)'(cprod3_r);
    ent_sum = {1'b0, ent_r} + (rcee_pkg::ENT_W + 1)'(term3_r);
    en_sum  = {1'b0, en_r} + (rcee_pkg::EN_W + 1)'(gsq3_r);
    con_nxt = con_sum[rcee_pkg::CON_W] ? '1 : con_sum[rcee_pkg::CON_W-1:0];
    ent_nxt = ent_sum[rcee_pkg::ENT_W] ? '1 : ent_sum[rcee_pkg::ENT_W-1:0];
    en_nxt  = en_sum[rcee_pkg::EN_W] ? '1 : en_sum[rcee_pkg::EN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      con_r <= '0;
      ent_r <= '0;
      en_r  <= '0;
    end else if (v3_r) begin
      if (l3_r) begin
        con_r <= '0;
        ent_r <= '0;
        en_r  <= '0;
      end else begin
        con_r <= con_nxt;
        ent_r <= ent_nxt;
        en_r  <= en_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && l3_r) begin
      con_fin_r <= con_nxt;
      ent_fin_r <= ent_nxt;
      en_fin_r  <= en_nxt;
    end
  end

  rcee_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (en_fin_r),
    .busy    (sqrt_busy),
    .root    (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      contrast <= con_fin_r;
      entropy  <= rcee_pkg::ENT_OUT_W'(0) - {1'b0, ent_fin_r};
      energy   <= root[rcee_pkg::ROOT_W-1] ? '1 : root[rcee_pkg::EN_OUT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.last_done = v3_r & l3_r;
  assign sts.sqrt_busy = sqrt_busy;
  assign sts.out_busy  = out_valid_r & ~out_ready;

endmodule

[rtl/rcee_ctrl.sv]
`timescale 1ns / 1ps

module rcee_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output rcee_pkg::cmd_t     cmd,
  input  rcee_pkg::sts_t     sts
);

  rcee_pkg::state_t state_r;
  rcee_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcee_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcee_pkg::ST_RUN: begin
        if (in_valid && in_last) state_nxt = rcee_pkg::ST_DRAIN;
      end
      rcee_pkg::ST_DRAIN: begin
        if (sts.last_done) state_nxt = rcee_pkg::ST_LOAD;
      end
      rcee_pkg::ST_LOAD: begin
        state_nxt = rcee_pkg::ST_ROOT;
      end
      rcee_pkg::ST_ROOT: begin
        if (!sts.sqrt_busy && !sts.out_busy) state_nxt = rcee_pkg::ST_RUN;
      end
      default: state_nxt = rcee_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.sqrt_start = 1'b0;
    cmd.load_out   = 1'b0;
    unique case (state_r)
      rcee_pkg::ST_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      rcee_pkg::ST_DRAIN: begin
      end
      rcee_pkg::ST_LOAD: begin
        cmd.sqrt_start = 1'b1;
      end
      rcee_pkg::ST_ROOT: begin
        cmd.load_out = ~sts.sqrt_busy & ~sts.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/region_contrast_entropy_energy.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// in_      in   in_tvalid / in_tready    tdata: column, row, gray; tlast: last pixel
// out_     out  out_tvalid / out_tready  tdata: contrast, entropy, energy
//
// Pixels of a region are taken one beat per cycle while in_tready is high. A beat with tlast
// drops in_tready while the product pipeline drains into the sums, the square root is started
// and run (one bit per cycle) and the output register is loaded. The next region streams in
// while the result waits; a result still waiting at the end of that region holds off the load
// and stretches the stall.
// Reset (rst_n low, synchronous) clears the sums, valid bits, controller and output flag.

module region_contrast_entropy_energy #(
  parameter int COORD_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // column[11:0], row[23:12], gray[31:24]
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata   // contrast[47:0], entropy[82:48], energy[106:83], zero
);

  rcee_pkg::cmd_t                   cmd;
  rcee_pkg::sts_t                   sts;
  logic [rcee_pkg::CON_W-1:0]       contrast;
  logic [rcee_pkg::ENT_OUT_W-1:0]   entropy;
  logic [rcee_pkg::EN_OUT_W-1:0]    energy;

  // sequencing: take pixels, wait out the pipeline, run the root, hand off the beat
  rcee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // products, table lookup, saturating sums, square root and output register
  rcee_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .column     (in_tdata[11:0]),
    .row        (in_tdata[23:12]),
    .gray       (in_tdata[31:24]),
    .last_pixel (in_tlast),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .contrast   (contrast),
    .entropy    (entropy),
    .energy     (energy)
  );

  assign out_tdata = {5'd0, energy, entropy, contrast};

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PIXELS  = 800;
  localparam int STEADY_PIXELS  = 230;

  localparam longint unsigned CONTRAST_MAX = (64'd1 << rcee_pkg::CON_W) - 1;
  localparam longint unsigned ENTROPY_MAX  = (64'd1 << rcee_pkg::ENT_W) - 1;
  localparam longint unsigned ENERGY_MAX   = (64'd1 << rcee_pkg::EN_W) - 1;
  localparam longint unsigned ROOT_MAX     = (64'd1 << rcee_pkg::EN_OUT_W) - 1;

  typedef struct {
    logic [rcee_pkg::CON_W-1:0]     contrast;
    logic [rcee_pkg::ENT_OUT_W-1:0] entropy;
    logic [rcee_pkg::EN_OUT_W-1:0]  energy;
  } region_stats_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;    // column[11:0], row[23:12], gray[31:24]
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;        // contrast[47:0], entropy[82:48], energy[106:83], zero

  // Running sums of the region currently streaming in
  longint unsigned contrast_acc;
  longint unsigned entropy_acc;
  longint unsigned energy_acc;
  region_stats_t   pending_stats[$];

  bit steady;
  int errors;
  int pixels_sent;
  int regions_sent;
  int regions_checked;
  int idle_cycles;

  region_contrast_entropy_energy #(
    .COORD_BITS(12)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // g*256*log10(g) in fixed point: log2 by repeated squaring, scale by log10(2), round
  function automatic longint unsigned gray_log_term(int unsigned g);
    longint unsigned expo;
    longint unsigned mant;
    longint unsigned lg2;
    longint unsigned frac_bit;
    longint unsigned scaled;
    if (g < 2) return 0;
    expo = 0;
    while ((g >> (expo + 1)) != 0) expo++;
    mant     = (longint'(g) << 30) >> expo;
    lg2      = expo << 30;
    frac_bit = 64'd1 << 29;
    repeat (30) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        lg2  = lg2 | frac_bit;
      end
      frac_bit = frac_bit >> 1;
    end
    scaled = (lg2 * 64'd323228497) >> 30;
    scaled = scaled * (longint'(g) << 8);
    return (scaled + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned clamp_add(longint unsigned acc, longint unsigned add,
                                                longint unsigned lim);
    if (acc > lim) acc = lim;
    if (add > lim - acc) return lim;
    return acc + add;
  endfunction

  // Fold one accepted pixel into the sums; queue the region's statistics on its last pixel
  task automatic accumulate_pixel(input logic [11:0] col, input logic [11:0] row,
                                  input logic [7:0] gray, input logic last);
    longint unsigned diff;
    longint unsigned root;
    region_stats_t   stats;
    diff = (row >= col) ? longint'(row - col) : longint'(col - row);
    contrast_acc = clamp_add(contrast_acc, diff * diff * gray, CONTRAST_MAX);
    entropy_acc  = clamp_add(entropy_acc, gray_log_term(gray), ENTROPY_MAX);
    energy_acc   = clamp_add(energy_acc, longint'(gray) * gray, ENERGY_MAX);
    if (last) begin
      root = int_sqrt(energy_acc << 16);
      if (root > ROOT_MAX) root = ROOT_MAX;
      stats.contrast = contrast_acc[rcee_pkg::CON_W-1:0];
      stats.entropy  = -{1'b0, entropy_acc[rcee_pkg::ENT_W-1:0]};
      stats.energy   = root[rcee_pkg::EN_OUT_W-1:0];
      pending_stats  = {pending_stats, stats};
      contrast_acc = 0;
      entropy_acc  = 0;
      energy_acc   = 0;
      regions_sent++;
    end
  endtask

  // Present one pixel beat, with random idle cycles ahead of it outside steady mode, and hold until taken
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [7:0] gray, input logic last);
    if (!steady) begin
      while ($urandom_range(99) < 9) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {gray, row, col};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate_pixel(col, row, gray, last);
    pixels_sent++;
  endtask

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_gray();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_region_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(32, 9);
    return $urandom_range(120, 33);
  endfunction

  task automatic stream_regions(input int pixel_budget);
    int target;
    int len;
    target = pixels_sent + pixel_budget;
    while (pixels_sent < target) begin
      len = pick_region_len();
      for (int i = 0; i < len; i++) begin
        send_pixel(pick_coord(), pick_coord(), pick_gray(), i == len - 1);
      end
    end
  endtask

  // Single-pixel regions: zero gray, unit gray, full gray at the widest spread, corner and mid-range cases
  task automatic test_single_pixel_regions();
    send_pixel(12'd0, 12'd0, 8'd0, 1'b1);
    send_pixel(12'd5, 12'd9, 8'd1, 1'b1);
    send_pixel(12'd7, 12'd3, 8'd2, 1'b1);
    send_pixel(12'hfff, 12'd0, 8'd255, 1'b1);
    send_pixel(12'd0, 12'hfff, 8'd255, 1'b1);
    send_pixel(12'd2048, 12'd2048, 8'd200, 1'b1);
    send_pixel(12'hfff, 12'hfff, 8'd128, 1'b1);
  endtask

  // Short regions mixing zero gray into the middle, an all-zero region, then a region at full spread and level
  task automatic test_short_regions();
    send_pixel(12'd10, 12'd20, 8'd100, 1'b0);
    send_pixel(12'd300, 12'd30, 8'd0, 1'b0);
    send_pixel(12'd4000, 12'd1, 8'd17, 1'b0);
    send_pixel(12'd1, 12'd1, 8'd1, 1'b1);
    send_pixel(12'd0, 12'd0, 8'd0, 1'b0);
    send_pixel(12'd0, 12'd0, 8'd0, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_pixel(i[0] ? 12'hfff : 12'd0, i[0] ? 12'd0 : 12'hfff, 8'd255, i == 7);
    end
  endtask

  task automatic test_random_regions();
    stream_regions(RANDOM_PIXELS);
  endtask

  // Back-to-back pixels with the result side always ready
  task automatic test_steady_stream();
    steady = 1'b1;
    stream_regions(STEADY_PIXELS);
    steady = 1'b0;
  endtask

  // Compare each result beat with the oldest queued region; randomize the ready line outside steady mode
  always @(posedge clk) begin
    region_stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_stats.size() == 0) begin
        $error("result beat with no region pending: tdata %h", out_tdata);
        errors++;
      end else begin
        want = pending_stats.pop_front();
        regions_checked++;
        if (out_tdata[47:0] !== want.contrast) begin
          $error("contrast: expected %0d, got %0d", want.contrast, out_tdata[47:0]);
          errors++;
        end
        if (out_tdata[82:48] !== want.entropy) begin
          $error("entropy: expected %0d, got %0d", $signed(want.entropy),
                 $signed(out_tdata[82:48]));
          errors++;
        end
        if (out_tdata[106:83] !== want.energy) begin
          $error("energy: expected %0d, got %0d", want.energy, out_tdata[106:83]);
          errors++;
        end
      end
    end
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 9);
  end

  // Drop the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    steady       = 1'b0;
    contrast_acc = 0;
    entropy_acc  = 0;
    energy_acc   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_pixel_regions();
    test_short_regions();
    test_random_regions();
    test_steady_stream();

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d pixels in %0d regions, %0d region results compared",
             pixels_sent, regions_sent, regions_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rcee_pkg.sv
rtl/rcee_sqrt.sv
rtl/rcee_dp.sv
rtl/rcee_ctrl.sv
rtl/region_contrast_entropy_energy.sv
verif/testbench.sv
